>>> hw/rtl/lkv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int COUNT_W = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 31;
  localparam int CAP_W   = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // register index taken from the word address
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] data;
  } rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/lkv_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_cfg
// APB register port holding the capacity register.
// ----------------------------------------------------------------------------
module lkv_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lkv_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lkv_pkg::DATA_W-1:0]  pwdata,
  output logic      [lkv_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [lkv_pkg::CAP_W-1:0]   capacity
);
  import lkv_pkg::*;

  logic reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (reg_index == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_CAPACITY) begin
      prdata = DATA_W'(capacity);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lkv_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_store
// Entry array with parallel key match, recency ranks and replacement.
// ----------------------------------------------------------------------------
module lkv_store (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  input  wire lkv_pkg::req_t              req,
  input  wire logic [lkv_pkg::CAP_W-1:0]  capacity,
  output lkv_pkg::rsp_t                   rsp
);
  import lkv_pkg::*;

  logic [ENTRIES-1:0]  valid, valid_next;
  logic [KEY_W-1:0]    keys [ENTRIES];
  logic [VAL_W-1:0]    vals [ENTRIES];
  logic [RANK_W-1:0]   rank [ENTRIES];
  logic [RANK_W-1:0]   rank_next [ENTRIES];
  logic [COUNT_W-1:0]  occ, occ_next;

  logic [ENTRIES-1:0]  hit_vec, lru_vec, valid_kept;
  logic                hit_any, free_any, evict;
  logic [SLOT_W-1:0]   hit_idx, free_idx, wr_idx;
  logic [RANK_W-1:0]   hit_rank;
  logic [COUNT_W-1:0]  eff_cap;
  logic                wr_key_en, wr_val_en;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = COUNT_W'(1);
    end else if (COUNT_W'(capacity) > COUNT_W'(ENTRIES)) begin
      eff_cap = COUNT_W'(ENTRIES);
    end else begin
      eff_cap = COUNT_W'(capacity);
    end
  end

  // match, least recent and first free slot
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (keys[i] == req.key);
      // ranks of valid slots are a permutation of 0..occ-1
      lru_vec[i] = valid[i] && (COUNT_W'(rank[i]) == (occ - COUNT_W'(1)));
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i] && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
    evict      = !hit_any && (req.op == OP_PUT) && (occ >= eff_cap);
    valid_kept = evict ? (valid & ~lru_vec) : valid;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!valid_kept[i] && !free_any) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
    hit_rank = rank[hit_idx];
  end

  always_comb begin
    rsp.found = hit_any;
    rsp.data  = hit_any ? vals[hit_idx] : '0;
  end

  // next state of valid bits, ranks and fill count
  always_comb begin
    valid_next = valid;
    rank_next  = rank;
    occ_next   = occ;
    wr_key_en  = 1'b0;
    wr_val_en  = 1'b0;
    wr_idx     = hit_idx;
    if (req_valid) begin
      if (hit_any) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && (rank[i] < hit_rank)) begin
            rank_next[i] = rank[i] + RANK_W'(1);
          end
        end
        rank_next[hit_idx] = '0;
        wr_val_en          = (req.op == OP_PUT);
      end else if (req.op == OP_PUT) begin
        valid_next = valid_kept;
        for (int i = 0; i < ENTRIES; i++) begin
          if (evict && lru_vec[i]) begin
            rank_next[i] = '0;
          end
        end
        occ_next = evict ? (occ - COUNT_W'(1)) : occ;
        if (free_any) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_kept[i]) begin
              rank_next[i] = rank[i] + RANK_W'(1);
            end
          end
          valid_next[free_idx] = 1'b1;
          rank_next[free_idx]  = '0;
          occ_next             = occ_next + COUNT_W'(1);
          wr_key_en            = 1'b1;
          wr_val_en            = 1'b1;
          wr_idx               = free_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      valid <= valid_next;
      occ   <= occ_next;
      rank  <= rank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      keys[wr_idx] <= req.key;
    end
    if (wr_val_en) begin
      vals[wr_idx] <= req.value;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative 16-entry key/value cache with LRU replacement.
// ----------------------------------------------------------------------------
// The block takes one request per clock on the slave stream and answers every
// get with one result on the master stream; puts give no result. A request is
// registered on entry, then once it advances all 16 keys are compared in
// parallel, the recency ranks are updated and the get result is loaded into
// the output register; the sustained rate is one request per cycle, set by
// that single store stage, while no get is stalled. Only a get whose result
// cannot be placed because the output register is still held stalls the
// input. Valid bits, ranks and the fill count clear at reset, so no clearing
// pass is needed. The capacity register (address 0, reset 16) limits how
// many pairs are held; 0 acts as 1 and values above 16 as 16. Write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // slave stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [63:0]                 s_tdata,  // key[31:0], value[62:32], zero[63]
  input  wire logic                        s_tuser,  // op[0]: 0 get, 1 put
  // master stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [31:0]                 m_tdata,  // data[30:0], zero[31]
  output logic                             m_tuser,  // found[0]
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lkv_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lkv_pkg::DATA_W-1:0]  pwdata,
  output logic      [lkv_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import lkv_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic             in_valid;
  req_t             in_req;
  logic             advance;
  rsp_t             store_rsp;
  logic             out_valid;
  rsp_t             out_rsp;

  lkv_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // advance the held request unless it is a get with nowhere to put its result
  assign advance  = in_valid && ((in_req.op == OP_PUT) || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.op    <= op_t'(s_tuser);
      in_req.key   <= s_tdata[KEY_W-1:0];
      in_req.value <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
  end

  lkv_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req_valid (advance),
    .req       (in_req),
    .capacity  (capacity),
    .rsp       (store_rsp)
  );

  // output register: load a get result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (in_req.op == OP_GET)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (in_req.op == OP_GET)) begin
      out_rsp <= store_rsp;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_rsp.data};
  assign m_tuser  = out_rsp.found;

endmodule
`default_nettype wire

>>> tb/lru_key_value_cache_checker.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_checker
// Watches the request, result and register ports of the LRU key/value cache,
// keeps its own copy of the cache contents and recency order, and compares
// every get result against the lookup it predicts.
// ----------------------------------------------------------------------------
module lru_key_value_cache_checker
  import lkv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [63:0]       s_tdata,   // key[31:0], value[62:32], zero[63]
  input  wire logic              s_tuser,   // op[0]
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [31:0]       m_tdata,   // data[30:0], zero[31]
  input  wire logic              m_tuser,   // found[0]
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic [DATA_W-1:0] prdata,
  input  wire logic              pready,
  output int                     errors,
  output int                     lookups_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic               slot_valid [ENTRIES];
  logic [KEY_W-1:0]   slot_key   [ENTRIES];
  logic [VAL_W-1:0]   slot_value [ENTRIES];
  logic [RANK_W-1:0]  slot_rank  [ENTRIES];
  logic [COUNT_W-1:0] fill_count;
  logic [CAP_W-1:0]   capacity_reg;

  rsp_t lookup_results_due[$];
  int   mismatch_count = 0;
  int   due_count = 0;

  assign errors          = mismatch_count;
  assign lookups_pending = due_count;

  function automatic int effective_capacity();
    if (capacity_reg == '0) return 1;
    if (int'(capacity_reg) > ENTRIES) return ENTRIES;
    return int'(capacity_reg);
  endfunction

  function automatic int slot_holding(input logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // make slot s the most recent; slots that were more recent age by one
  function automatic void promote_slot(input int s);
    logic [RANK_W-1:0] r;
    r = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i] = slot_rank[i] + 1'b1;
    slot_rank[s] = '0;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && (best < 0 || slot_rank[i] > slot_rank[best])) best = i;
    return best;
  endfunction

  // evict one pair when at or above capacity, then fill the lowest free slot
  function automatic void insert_pair(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    int victim;
    int free_slot;
    free_slot = -1;
    if (int'(fill_count) >= effective_capacity()) begin
      victim = oldest_slot();
      if (victim >= 0) begin
        slot_valid[victim] = 1'b0;
        slot_rank[victim]  = '0;
        fill_count         = fill_count - 1'b1;
      end
    end
    for (int i = 0; i < ENTRIES; i++)
      if (!slot_valid[i] && free_slot < 0) free_slot = i;
    if (free_slot < 0) return;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) slot_rank[i] = slot_rank[i] + 1'b1;
    slot_valid[free_slot] = 1'b1;
    slot_key[free_slot]   = k;
    slot_value[free_slot] = v;
    slot_rank[free_slot]  = '0;
    fill_count            = fill_count + 1'b1;
  endfunction

  function automatic void apply_request(input op_t op, input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v);
    int   s;
    rsp_t res;
    s = slot_holding(k);
    if (op == OP_GET) begin
      res.found = 1'b0;
      res.data  = '0;
      if (s >= 0) begin
        promote_slot(s);
        res.found = 1'b1;
        res.data  = slot_value[s];
      end
      lookup_results_due.push_back(res);
    end else if (s >= 0) begin
      slot_value[s] = v;
      promote_slot(s);
    end else begin
      insert_pair(k, v);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_rank[i]  = '0;
      end
      fill_count   = '0;
      capacity_reg = CAP_RESET;
      lookup_results_due.delete();
    end else begin
      // register port: only the capacity index is decoded
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_CAPACITY) begin
        if (pwrite) begin
          capacity_reg = pwdata[CAP_W-1:0];
        end else if (prdata !== DATA_W'(capacity_reg)) begin
          mismatch_count++;
          $display("%0t: capacity readback mismatch, expected %0d actual %0d",
                   $time, capacity_reg, prdata);
        end
      end
      if (m_tvalid && m_tready) begin
        if (lookup_results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none actual found=%0b data=%h",
                   $time, m_tuser, m_tdata[VAL_W-1:0]);
        end else begin
          want = lookup_results_due.pop_front();
          if (m_tuser !== want.found) begin
            mismatch_count++;
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, m_tuser);
          end
          if (m_tdata[VAL_W-1:0] !== want.data) begin
            mismatch_count++;
            $display("%0t: data mismatch, expected %h actual %h",
                     $time, want.data, m_tdata[VAL_W-1:0]);
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_request(op_t'(s_tuser), s_tdata[KEY_W-1:0], s_tdata[KEY_W+VAL_W-1:KEY_W]);
    end
    due_count = lookup_results_due.size();
  end

endmodule

>>> tb/lru_key_value_cache_tb.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Drives gets and puts into the LRU key/value cache through a sequence of
// capacity settings, with random gaps and result back-pressure, and leaves
// all result checking to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  import lkv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // capacity is register index 0; index 1 lies beyond the register list
  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR    = {~REG_CAPACITY, 2'b00};
  localparam int POOL_SIZE     = 40;
  localparam int NUM_PHASES    = 11;
  localparam int PHASE_ITEMS   = 140;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [63:0]       s_tdata;   // key[31:0], value[62:32], zero[63]
  logic              s_tuser;   // op[0]: 0 get, 1 put
  logic              m_tvalid;
  logic              m_tready;
  logic [31:0]       m_tdata;   // data[30:0], zero[31]
  logic              m_tuser;   // found[0]
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int errors;
  int lookups_pending;

  // stimulus-to-receiver controls
  logic calm;            // no idling on either side
  logic hold_request;    // ask the receiver for one long hold-off

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               phase_caps [NUM_PHASES];

  lru_key_value_cache u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lru_key_value_cache_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .errors          (errors),
    .lookups_pending (lookups_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a correct run finishes in well under a tenth of this.
  initial begin
    #4_000_000;
    $display("lru_key_value_cache verification failed");
    $finish;
  end

  // Result receiver. Drop tready in random bursts, grant the one long
  // hold-off on request (the sender keeps offering meanwhile, so the block
  // backs up and stalls its input), and stay ready once the run goes calm.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // Offer one transaction; called at a falling edge, returns at the falling
  // edge after acceptance with tvalid still high.
  task automatic send_request(input op_t op, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, v, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold the input idle until every get has been answered, then give the
  // block time to retire any put still in its pipeline.
  task automatic drain_lookups();
    s_tvalid <= 1'b0;
    while (lookups_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input logic is_write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Upper data bits are junk on purpose: only the low five bits count.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain_lookups();
    apb_access(1'b1, CAPACITY_ADDR, {(DATA_W-CAP_W)'($urandom), cap});
    apb_access(1'b0, CAPACITY_ADDR, '0);
  endtask

  // Mostly keys from a small pool so gets hit and puts collide; now and then
  // a fresh random key or one of the key extremes.
  task automatic send_random_request(input int span);
    int               r;
    op_t              op;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    if ($urandom_range(0, 49) == 0) key_pool[$urandom_range(0, POOL_SIZE-1)] = $urandom;
    op = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
    r  = $urandom_range(0, 99);
    if (r < 88)      k = key_pool[$urandom_range(0, span-1)];
    else if (r < 94) k = $urandom;
    else if (r < 97) k = '0;
    else             k = '1;
    r = $urandom_range(0, 99);
    if (r < 4)      v = '0;
    else if (r < 8) v = '1;
    else            v = VAL_W'($urandom);
    send_request(op, k, v);
  endtask

  initial begin
    int cap;
    int eff;
    int span;
    rst          = 1'b1;
    calm         = 1'b0;
    hold_request = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_GET;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    phase_caps = '{16, 4, 1, 9, 27, 0, 2, 16, 6, 13, 16};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: get on an empty cache, key and value extremes, a put that
    // replaces a value, a miss on a non-empty cache.
    send_request(OP_GET, 32'h0000_0005, VAL_W'($urandom));
    send_request(OP_PUT, 32'h0000_0000, 31'h0000_0000);
    send_request(OP_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(OP_GET, 32'h0000_0000, 31'h7FFF_FFFF);
    send_request(OP_GET, 32'hFFFF_FFFF, 31'h0000_0000);
    send_request(OP_PUT, 32'h0000_0000, 31'h2AAA_AAAA);
    send_request(OP_GET, 32'h0000_0000, 31'h5555_5555);
    send_request(OP_GET, 32'h1234_5678, 31'h0000_0000);

    // Capacity zero acts as one; two pairs are already held, so each
    // missing put now evicts exactly one least recent pair. A write to the
    // index beyond the register list must leave capacity alone.
    set_capacity(5'd0);
    apb_access(1'b1, SPARE_ADDR, 32'h0000_0009);
    apb_access(1'b0, CAPACITY_ADDR, '0);
    send_request(OP_PUT, 32'h0000_0011, 31'h5555_5555);
    send_request(OP_GET, 32'h0000_0011, 31'h0000_0000);
    send_request(OP_PUT, 32'h0000_0022, 31'h0000_0001);
    send_request(OP_GET, 32'h0000_0011, 31'h0000_0000);

    // Capacity two: a get refreshes recency and changes the victim.
    set_capacity(5'd2);
    send_request(OP_PUT, 32'h0000_0033, 31'h0000_0003);
    send_request(OP_PUT, 32'h0000_0044, 31'h0000_0004);
    send_request(OP_GET, 32'h0000_0033, 31'h0000_0000);
    send_request(OP_PUT, 32'h0000_0055, 31'h0000_0005);
    send_request(OP_GET, 32'h0000_0044, 31'h0000_0000);
    send_request(OP_GET, 32'h0000_0033, 31'h0000_0000);

    // Capacity above the entry count saturates.
    set_capacity(5'd31);

    // Random phases. Capacity steps down right after full-size phases so the
    // cache runs above its limit; the final phase runs with no idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      cap = phase_caps[p];
      calm = (p == NUM_PHASES - 1);
      set_capacity(CAP_W'(cap));
      eff  = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
      span = eff + $urandom_range(1, 8);
      if (span > POOL_SIZE) span = POOL_SIZE;
      if (p == 2) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // pause the sender mid-phase until every result is back
        if (p == 4 && n == PHASE_ITEMS / 2) drain_lookups();
        if (!calm && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 18));
        send_random_request(span);
      end
    end

    drain_lookups();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("lru_key_value_cache verification clean");
    else
      $display("lru_key_value_cache verification failed");
    $finish;
  end

endmodule

>>> lru_key_value_cache.f
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_cfg.sv
hw/rtl/lkv_store.sv
hw/rtl/lru_key_value_cache.sv
tb/lru_key_value_cache_checker.sv
tb/lru_key_value_cache_tb.sv
